// ----- hw/rtl/newton_nth_root_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the n-th root block
// Shared forms for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEWTON_NTH_ROOT_ASSERT_SVH
`define NEWTON_NTH_ROOT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NNR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/nnr_pkg.sv -----
// ----------------------------------------------------------------------------
// nnr_pkg
// Types and fixed constants of the Newton n-th root block.
// ----------------------------------------------------------------------------
`default_nettype none

package nnr_pkg;

	// Field widths
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned DEGREE_W = 4;
	localparam int unsigned TOL_W    = 24;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 2;

	// Quotient is capped at 2^40, so it needs 41 bits.
	localparam int unsigned QUOT_W = 41;
	localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

	// Magnitude of (quotient - root) never exceeds 2^40.
	localparam int unsigned DELTA_BITS = 41;
	localparam int unsigned DIFF_W     = 42;

	// Degree limits
	localparam logic [DEGREE_W-1:0] DEGREE_MIN = 4'd2;
	localparam logic [DEGREE_W-1:0] DEGREE_MAX = 4'd8;

	// Register reset values
	localparam logic [DEGREE_W-1:0] RST_ROOT_DEGREE    = 4'd5;
	localparam logic [WORD_W-1:0]   RST_START_GUESS    = 32'd15099494;
	localparam logic [TOL_W-1:0]    RST_STOP_TOLERANCE = 24'd167772;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [1:0] REG_ROOT_DEGREE    = 2'd0;
	localparam logic [1:0] REG_START_GUESS    = 2'd1;
	localparam logic [1:0] REG_STOP_TOLERANCE = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FAULT     = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_POW_MUL,
		S_POW_SHIFT,
		S_DIV_Q,
		S_ABS,
		S_DIV_D,
		S_DONE
	} nnr_state_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nnr_if.sv -----
// ----------------------------------------------------------------------------
// nnr_if
// Valid/ready channels carrying the radicand in and the root result out.
// ----------------------------------------------------------------------------
`default_nettype none

// Radicand channel
interface nnr_in_if import nnr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

// Result channel
interface nnr_out_if import nnr_pkg::*;;
	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   root_value;
	logic [COUNT_W-1:0]  iteration_count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output root_value, output iteration_count,
		output status, input ready);
	modport sink   (input valid, input root_value, input iteration_count,
		input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nnr_divider.sv -----
// ----------------------------------------------------------------------------
// nnr_divider
// Restoring divider, one quotient bit per cycle, quotient capped at 2^40.
// ----------------------------------------------------------------------------
`default_nettype none

module nnr_divider import nnr_pkg::*; #(
	parameter  int unsigned NUM_W = 56,
	localparam int unsigned CNT_W = $clog2(NUM_W + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CNT_W-1:0]  steps,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [WORD_W-1:0] den,
	output logic      [QUOT_W-1:0] quotient,
	output div_stat_t              stat
);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_q;
	logic [NUM_W-1:0]  num_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   trial;
	logic              fits;
	logic [QUOT_W-1:0] quot_cand;
	logic [QUOT_W-1:0] quot_next;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		shifted   = {rem_q, num_q[NUM_W-1]};
		trial     = shifted - {1'b0, den_q};
		fits      = (shifted >= {1'b0, den_q});
		quot_cand = {quot_q[QUOT_W-2:0], fits};
		if (quot_q < QUOT_CAP) begin
			quot_next = (quot_cand > QUOT_CAP) ? QUOT_CAP : quot_cand;
		end else begin
			quot_next = quot_q;
		end
	end

	// Step counter and handshake toward the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend shift register and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			num_q  <= num;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= quot_next;
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/newton_nth_root.sv -----
// ----------------------------------------------------------------------------
// newton_nth_root
// Newton iteration for the n-th root of an unsigned fixed-point radicand.
// ----------------------------------------------------------------------------
// The block takes one radicand at a time and returns its n-th root, the
// number of Newton steps applied and a status (converged, iteration limit,
// or underflow/saturation). Each step forms x^(n-1) on one 32x32 multiplier,
// divides radicand * 2^FRACTION_BITS by it on a bit-serial divider, and,
// after the S_ABS state, divides the correction by n on the same divider.
// An item takes at most MAX_ITERATIONS steps. The input is not ready while
// an item is in work; a finished result waits in an output register, so the
// next radicand may be taken before the previous result is drained.
// ----------------------------------------------------------------------------
`default_nettype none

`include "newton_nth_root_assert.svh"

module newton_nth_root import nnr_pkg::*; #(
	parameter int unsigned MAX_ITERATIONS = 64,
	parameter int unsigned FRACTION_BITS  = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	nnr_in_if.sink                     sample,
	nnr_out_if.source                  result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int unsigned DIV_NUM_W = WORD_W + FRACTION_BITS;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// Configuration registers
	logic [DEGREE_W-1:0] root_degree_q;
	logic [WORD_W-1:0]   start_guess_q;
	logic [TOL_W-1:0]    stop_tolerance_q;

	// Sequencer and datapath state
	nnr_state_t          state_q;
	nnr_state_t          state_d;
	logic [WORD_W-1:0]   p_q;
	logic [WORD_W-1:0]   x_q;
	logic [WORD_W-1:0]   pw_q;
	logic [2*WORD_W-1:0] prod_q;
	logic [2:0]          pow_left_q;
	logic [DEGREE_W-1:0] n_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [COUNT_W-1:0]  count_q;
	logic [STATUS_W-1:0] res_status_q;

	// Output register
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_root_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [STATUS_W-1:0] out_status_q;

	// Sequencer controls
	logic in_ready;
	logic mul_en;
	logic shift_en;
	logic underflow_en;
	logic div_start;
	logic div_sel_delta;
	logic diff_en;
	logic update_en;
	logic out_load;

	// Divider connection
	logic [DIV_CNT_W-1:0] div_steps;
	logic [DIV_NUM_W-1:0] div_num;
	logic [WORD_W-1:0]    div_den;
	logic [QUOT_W-1:0]    div_quot;
	div_stat_t            div_stat;

	// Combinational datapath
	logic                     cfg_write;
	logic [DEGREE_W-1:0]      degree_clamped;
	logic [2*WORD_W-1:0]      prod_scaled;
	logic [WORD_W-1:0]        pw_capped;
	logic signed [DIFF_W-1:0] diff_new;
	logic [DIFF_W-1:0]        diff_abs;
	logic signed [DIFF_W-1:0] nx;
	logic                     nx_sat;
	logic [WORD_W-1:0]        x_new;
	logic [COUNT_W-1:0]       count_next;
	logic                     step_conv;
	logic                     step_limit;
	logic                     update_finish;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------

	// A write completes in the access phase; pready never stalls.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_degree_q    <= RST_ROOT_DEGREE;
			start_guess_q    <= RST_START_GUESS;
			stop_tolerance_q <= RST_STOP_TOLERANCE;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_ROOT_DEGREE:    root_degree_q    <= pwdata[DEGREE_W-1:0];
				REG_START_GUESS:    start_guess_q    <= pwdata[WORD_W-1:0];
				REG_STOP_TOLERANCE: stop_tolerance_q <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_ROOT_DEGREE:    prdata = {{(APB_DATA_W-DEGREE_W){1'b0}}, root_degree_q};
			REG_START_GUESS:    prdata = start_guess_q;
			REG_STOP_TOLERANCE: prdata = {{(APB_DATA_W-TOL_W){1'b0}}, stop_tolerance_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath arithmetic
	// ------------------------------------------------------------------

	always_comb begin
		// Degrees outside 2..8 are pulled to the nearest end.
		if (root_degree_q < DEGREE_MIN) begin
			degree_clamped = DEGREE_MIN;
		end else if (root_degree_q > DEGREE_MAX) begin
			degree_clamped = DEGREE_MAX;
		end else begin
			degree_clamped = root_degree_q;
		end

		// Rescale the registered product and cap it to one word.
		prod_scaled = prod_q >> FRACTION_BITS;
		pw_capped   = (|prod_scaled[2*WORD_W-1:WORD_W]) ? '1 : prod_scaled[WORD_W-1:0];

		// Signed difference between the quotient and the current root.
		diff_new = $signed({1'b0, div_quot}) - $signed({{(DIFF_W-WORD_W){1'b0}}, x_q});
		diff_abs = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

		// The divider now holds |delta|; apply it with the sign of the difference.
		if (diff_q[DIFF_W-1]) begin
			nx = $signed({{(DIFF_W-WORD_W){1'b0}}, x_q}) - $signed({1'b0, div_quot});
		end else begin
			nx = $signed({{(DIFF_W-WORD_W){1'b0}}, x_q}) + $signed({1'b0, div_quot});
		end
		nx_sat = !nx[DIFF_W-1] && (|nx[DIFF_W-2:WORD_W]);
		if (nx[DIFF_W-1]) begin
			x_new = '0;
		end else if (nx_sat) begin
			x_new = '1;
		end else begin
			x_new = nx[WORD_W-1:0];
		end

		count_next    = count_q + 1'b1;
		step_conv     = div_quot <= {{(QUOT_W-TOL_W){1'b0}}, stop_tolerance_q};
		step_limit    = count_next == COUNT_W'(MAX_ITERATIONS);
		update_finish = nx_sat || step_conv || step_limit;
	end

	// Divider operand selection: first the quotient, then the division by n.
	always_comb begin
		if (div_sel_delta) begin
			div_steps = DIV_CNT_W'(DELTA_BITS);
			div_num   = {diff_abs[DELTA_BITS-1:0], {(DIV_NUM_W-DELTA_BITS){1'b0}}};
			div_den   = {{(WORD_W-DEGREE_W){1'b0}}, n_q};
		end else begin
			div_steps = DIV_CNT_W'(DIV_NUM_W);
			div_num   = {p_q, {FRACTION_BITS{1'b0}}};
			div_den   = pw_q;
		end
	end

	nnr_divider #(
		.NUM_W (DIV_NUM_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.num      (div_num),
		.den      (div_den),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sample.valid) state_d = S_POW_MUL;
			end
			S_POW_MUL: begin
				if (pow_left_q != '0) begin
					state_d = S_POW_SHIFT;
				end else if (pw_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV_Q;
				end
			end
			S_POW_SHIFT: state_d = S_POW_MUL;
			S_DIV_Q: begin
				if (div_stat.done) state_d = S_ABS;
			end
			S_ABS: state_d = S_DIV_D;
			S_DIV_D: begin
				if (div_stat.done) state_d = update_finish ? S_DONE : S_POW_MUL;
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready      = 1'b0;
		mul_en        = 1'b0;
		shift_en      = 1'b0;
		underflow_en  = 1'b0;
		div_start     = 1'b0;
		div_sel_delta = 1'b0;
		diff_en       = 1'b0;
		update_en     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_POW_MUL: begin
				if (pow_left_q != '0) begin
					mul_en = 1'b1;
				end else if (pw_q == '0) begin
					underflow_en = 1'b1;
				end else begin
					div_start = 1'b1;
				end
			end
			S_POW_SHIFT: shift_en = 1'b1;
			S_DIV_Q:     diff_en  = div_stat.done;
			S_ABS: begin
				div_start     = 1'b1;
				div_sel_delta = 1'b1;
			end
			S_DIV_D:     update_en = div_stat.done;
			S_DONE:      out_load  = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_ready && sample.valid) begin
				count_q <= '0;
			end else if (update_en) begin
				count_q <= count_next;
			end
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (in_ready && sample.valid) begin
			p_q        <= sample.radicand;
			x_q        <= start_guess_q;
			pw_q       <= start_guess_q;
			n_q        <= degree_clamped;
			pow_left_q <= 3'(degree_clamped - DEGREE_MIN);
		end
		if (mul_en) begin
			prod_q <= pw_q * x_q;
		end
		if (shift_en) begin
			pw_q       <= pw_capped;
			pow_left_q <= pow_left_q - 1'b1;
		end
		if (underflow_en) begin
			res_status_q <= STATUS_FAULT;
		end
		if (diff_en) begin
			diff_q <= diff_new;
		end
		if (update_en) begin
			x_q        <= x_new;
			pw_q       <= x_new;
			pow_left_q <= 3'(n_q - DEGREE_MIN);
			if (nx_sat) begin
				res_status_q <= STATUS_FAULT;
			end else if (step_conv) begin
				res_status_q <= STATUS_CONVERGED;
			end else begin
				res_status_q <= STATUS_LIMIT;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_root_q   <= x_q;
			out_count_q  <= count_q;
			out_status_q <= res_status_q;
		end
	end

	assign sample.ready           = in_ready;
	assign result.valid           = out_valid_q;
	assign result.root_value      = out_root_q;
	assign result.iteration_count = out_count_q;
	assign result.status          = out_status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	`NNR_ASSERT_NEXT(a_accept_starts_item, sample.valid && sample.ready,
		state_q == S_POW_MUL && count_q == '0, "accepted item did not start a fresh step")
	`NNR_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= COUNT_W'(MAX_ITERATIONS),
		"step count beyond the iteration cap")
	`NNR_ASSERT_SAME(a_div_wait_covered, state_q == S_DIV_Q || state_q == S_DIV_D,
		div_stat.busy || div_stat.done, "sequencer waits on an idle divider")
	`NNR_ASSERT_SAME(a_div_done_expected, div_stat.done,
		state_q == S_DIV_Q || state_q == S_DIV_D, "divider finished outside a divide state")
	`NNR_ASSERT_NEXT(a_restart_from_root, update_en && !update_finish,
		state_q == S_POW_MUL && pw_q == x_q, "next step does not start from the new root")

endmodule

`default_nettype wire

// ----- sim/tb_newton_nth_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_nth_root
// Self-checking testbench for the Newton n-th root block.
// ----------------------------------------------------------------------------
// A directed pass covers the extreme radicands, degrees outside the legal
// range, start guesses that underflow or overshoot, and the loosest and
// tightest tolerances. Phases of random radicands under random register
// settings follow. A scoreboard predicts every root from the radicand and its
// own copy of the registers, then checks each result transfer in order. Both
// channels idle at random, the receiver once holds off long enough to back
// up the input, and the sender once drains the block in mid-phase.
// ----------------------------------------------------------------------------

module tb_newton_nth_root;
	import nnr_pkg::*;

	localparam int unsigned MAX_ITER      = 64;
	localparam int          FRAC_BITS     = 24;
	localparam longint unsigned RUN_LIMIT = 16_000_000;
	localparam int unsigned RANDOM_PHASES = 15;
	localparam int unsigned PHASE_ITEMS   = 30;
	localparam int unsigned REGIME_SPAN   = 156;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LONG_HOLD     = 20000;
	localparam logic [63:0] WORD_MAX64    = 64'h0000_0000_FFFF_FFFF;

	typedef struct packed {
		logic [WORD_W-1:0]   root_value;
		logic [COUNT_W-1:0]  iteration_count;
		logic [STATUS_W-1:0] status;
	} root_result_t;

	// Scoreboard: register copy, root predictor and queue of expected roots.
	class root_scoreboard;
		logic [DEGREE_W-1:0] degree;
		logic [WORD_W-1:0]   guess;
		logic [TOL_W-1:0]    tolerance;
		root_result_t        expected_roots[$];
		int unsigned         failures;
		int unsigned         radicands_seen;
		int unsigned         results_seen;
		int unsigned         status_seen[4];

		function new();
			degree         = RST_ROOT_DEGREE;
			guess          = RST_START_GUESS;
			tolerance      = RST_STOP_TOLERANCE;
			failures       = 0;
			radicands_seen = 0;
			results_seen   = 0;
			status_seen    = '{0, 0, 0, 0};
		endfunction

		function void set_register(logic [1:0] index, logic [APB_DATA_W-1:0] value);
			case (index)
				REG_ROOT_DEGREE:    degree    = value[DEGREE_W-1:0];
				REG_START_GUESS:    guess     = value[WORD_W-1:0];
				REG_STOP_TOLERANCE: tolerance = value[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_roots.size();
		endfunction

		// Degrees outside two to eight are clamped to the nearest end.
		function int unsigned effective_degree();
			if (degree < DEGREE_MIN) return DEGREE_MIN;
			if (degree > DEGREE_MAX) return DEGREE_MAX;
			return degree;
		endfunction

		// x raised to a power, truncated after each product and capped at a word.
		function logic [63:0] root_power(logic [63:0] x, int unsigned exponent);
			logic [63:0] pw;
			int unsigned k;
			pw = x;
			for (k = 1; k < exponent; k++) begin
				pw = (pw * x) >> FRAC_BITS;
				if (pw > WORD_MAX64) pw = WORD_MAX64;
			end
			return pw;
		endfunction

		// Restoring division of num * 2^FRAC_BITS by den, with the quotient capped.
		function logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
			logic [63:0] rem, q, bit_in;
			int i;
			rem = '0;
			q   = '0;
			for (i = 31 + FRAC_BITS; i >= 0; i--) begin
				bit_in = '0;
				if (i >= FRAC_BITS) bit_in = (num >> (i - FRAC_BITS)) & 64'd1;
				rem    = (rem << 1) | bit_in;
				bit_in = '0;
				if (rem >= den) begin
					rem    = rem - den;
					bit_in = 64'd1;
				end
				if (q < QUOT_CAP) begin
					q = (q << 1) | bit_in;
					if (q > QUOT_CAP) q = QUOT_CAP;
				end
			end
			return q;
		endfunction

		// Newton iteration on one radicand under the current settings.
		function root_result_t predict(logic [WORD_W-1:0] radicand);
			root_result_t        r;
			int unsigned         n, steps;
			logic [63:0]         x, pw, q;
			longint              delta, nx, mag;
			logic [STATUS_W-1:0] st;
			n     = effective_degree();
			x     = guess;
			steps = 0;
			st    = STATUS_LIMIT;
			while (steps < MAX_ITER) begin
				pw = root_power(x, n - 1);
				if (pw == 0) begin
					st = STATUS_FAULT;
					break;
				end
				q     = scaled_quotient(radicand, pw);
				delta = (longint'(q) - longint'(x)) / longint'(n);
				nx    = longint'(x) + delta;
				steps++;
				if (nx > longint'(WORD_MAX64)) begin
					x  = WORD_MAX64;
					st = STATUS_FAULT;
					break;
				end
				if (nx < 0) nx = 0;
				x   = nx;
				mag = (delta < 0) ? -delta : delta;
				if (mag <= longint'(tolerance)) begin
					st = STATUS_CONVERGED;
					break;
				end
			end
			r.root_value      = x[WORD_W-1:0];
			r.iteration_count = COUNT_W'(steps);
			r.status          = st;
			return r;
		endfunction

		function void note_radicand(logic [WORD_W-1:0] radicand);
			expected_roots.push_back(predict(radicand));
			radicands_seen++;
		endfunction

		function void check_root(logic [WORD_W-1:0] root, logic [COUNT_W-1:0] count,
				logic [STATUS_W-1:0] status);
			root_result_t want;
			results_seen++;
			if (expected_roots.size() == 0) begin
				failures++;
				$display("%0t: result transfer with nothing expected, root %h count %0d status %0d",
					$time, root, count, status);
				return;
			end
			want = expected_roots.pop_front();
			if (status < 4) status_seen[status]++;
			if (root !== want.root_value) begin
				failures++;
				$display("%0t: root_value mismatch, expected %h, actual %h",
					$time, want.root_value, root);
			end
			if (count !== want.iteration_count) begin
				failures++;
				$display("%0t: iteration_count mismatch, expected %0d, actual %0d",
					$time, want.iteration_count, count);
			end
			if (status !== want.status) begin
				failures++;
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, status);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	nnr_in_if  sample_ch ();
	nnr_out_if result_ch ();

	root_scoreboard  roots;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	int unsigned     hold_request;
	int unsigned     accepted_count;
	int unsigned     settings_written;
	longint unsigned cycle_count;

	newton_nth_root #(
		.MAX_ITERATIONS(MAX_ITER),
		.FRACTION_BITS (FRAC_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Clock.
	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle limit on the whole run.
	initial begin : run_limit
		cycle_count = 0;
		while (cycle_count <= RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: cycle limit reached with %0d results outstanding",
			$time, roots.pending());
		$display("Mismatches found");
		$finish;
	end

	// Monitor: note each radicand transfer and check each result transfer.
	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			roots.note_radicand(sample_ch.radicand);
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			roots.check_root(result_ch.root_value, result_ch.iteration_count, result_ch.status);
		end
	end

	// Result receiver: random idling, plus a long hold-off on request.
	initial begin : result_drain
		int unsigned hold_left;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request <= 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Wait until every radicand sent so far has its result back.
	task automatic wait_results();
		do @(posedge clk); while (roots.pending() != 0);
	endtask

	// One register write over the configuration port, with the block idle.
	task automatic program_reg(logic [1:0] index, logic [APB_DATA_W-1:0] value);
		sample_ch.valid <= 1'b0;
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		roots.set_register(index, value);
		settings_written++;
	endtask

	task automatic configure(logic [DEGREE_W-1:0] deg, logic [WORD_W-1:0] guess,
			logic [TOL_W-1:0] tol);
		program_reg(REG_ROOT_DEGREE, APB_DATA_W'(deg));
		program_reg(REG_START_GUESS, APB_DATA_W'(guess));
		program_reg(REG_STOP_TOLERANCE, APB_DATA_W'(tol));
	endtask

	// Offer one radicand after a random gap and wait for its transfer.
	task automatic send_radicand(logic [WORD_W-1:0] value);
		int unsigned gap;
		gap = 0;
		while (gap < 1000 && $urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.radicand <= value;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		accepted_count++;
		// Idling regimes: sender light and receiver heavy, then swapped, then none.
		if (accepted_count == REGIME_SPAN) begin
			send_idle_pct = 87;
			recv_idle_pct <= 10;
		end else if (accepted_count == 2 * REGIME_SPAN) begin
			send_idle_pct = 0;
			recv_idle_pct <= 0;
		end
	endtask

	function automatic logic [WORD_W-1:0] random_radicand();
		case ($urandom_range(0, 3))
			0:       return $urandom();
			1:       return $urandom_range(0, 32'h00FF_FFFF);
			2:       return {8'($urandom_range(0, 255)), 24'h0};
			default: return $urandom_range(32'h0100_0000, 32'h1000_0000);
		endcase
	endfunction

	task automatic run_directed();
		// Reset settings: zero, full scale, one LSB, one, a perfect fifth power, and 128.
		send_radicand(32'h0000_0000);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0100_0000);
		send_radicand(32'h2000_0000);
		send_radicand(32'h8000_0000);
		// Square root from one LSB: the first step overshoots past full scale.
		configure(DEGREE_MIN, 32'd1, RST_STOP_TOLERANCE);
		send_radicand(32'h0100_0000);
		send_radicand(32'h0000_0000);
		// Fifth root from one LSB: the power underflows before any step.
		program_reg(REG_ROOT_DEGREE, APB_DATA_W'(RST_ROOT_DEGREE));
		send_radicand(32'h1234_5678);
		// A zero start guess returns zero at once.
		program_reg(REG_START_GUESS, '0);
		send_radicand(32'h0100_0000);
		// Degree below the range, used as two, with the loosest tolerance.
		configure(4'd0, 32'h0100_0000, '1);
		send_radicand(32'h0400_0000);
		send_radicand(32'hFFFF_FFFF);
		// Degree above the range, used as eight, full-scale guess, exact tolerance.
		configure(4'd15, '1, '0);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_0000);
		// Degree one, used as two.
		configure(4'd1, 32'h0100_0000, '0);
		send_radicand(32'h0200_0000);
		send_radicand(32'h5555_5555);
		// Degree nine, used as eight.
		configure(4'd9, 32'h0080_0000, 24'h00_0100);
		send_radicand(32'hAAAA_AAAA);
		send_radicand(32'h0000_0100);
	endtask

	task automatic run_random_phase(int unsigned phase);
		logic [DEGREE_W-1:0] deg;
		logic [WORD_W-1:0]   guess;
		logic [TOL_W-1:0]    tol;
		int unsigned         item;
		deg = ($urandom_range(0, 4) == 0) ? DEGREE_W'($urandom_range(0, 15))
			: DEGREE_W'($urandom_range(2, 8));
		guess = ($urandom_range(0, 3) == 0) ? $urandom()
			: $urandom_range(32'h0040_0000, 32'h0400_0000);
		case ($urandom_range(0, 9))
			0:       tol = '0;
			1:       tol = '1;
			2, 3:    tol = TOL_W'($urandom());
			default: tol = TOL_W'($urandom_range(32'h0000_1000, 32'h0004_0000));
		endcase
		// A few phases pin the settings to their extremes.
		if (phase == 0) begin
			deg = DEGREE_MIN;
			tol = '1;
		end else if (phase == 1) begin
			deg   = DEGREE_MAX;
			guess = '1;
		end else if (phase == 2) begin
			guess = 32'd1;
		end
		configure(deg, guess, tol);
		// Receiver holds off while the sender keeps offering, so the input stalls.
		if (phase == 3) hold_request <= LONG_HOLD;
		for (item = 0; item < PHASE_ITEMS; item++) begin
			// Sender pauses in mid-phase until the block has drained.
			if (phase == 7 && item == PHASE_ITEMS / 2) begin
				sample_ch.valid <= 1'b0;
				wait_results();
			end
			send_radicand(random_radicand());
		end
	endtask

	// Main sequence: reset, directed pass, random phases, drain and verdict.
	initial begin : stimulus
		int unsigned phase;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		sample_ch.valid    = 1'b0;
		sample_ch.radicand = '0;
		send_idle_pct      = 10;
		recv_idle_pct      = 87;
		hold_request       = 0;
		accepted_count     = 0;
		settings_written   = 0;
		roots              = new();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			run_random_phase(phase);
		end

		sample_ch.valid <= 1'b0;
		wait_results();
		repeat (SETTLE_CYCLES * 8) @(posedge clk);

		$display("Checked %0d results against %0d radicands over %0d register writes.",
			roots.results_seen, roots.radicands_seen, settings_written);
		$display("Statuses: %0d converged, %0d at iteration limit, %0d underflow or saturation.",
			roots.status_seen[STATUS_CONVERGED], roots.status_seen[STATUS_LIMIT],
			roots.status_seen[STATUS_FAULT]);
		if (roots.failures == 0 && roots.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
